// File: src/hcbp_pkg.sv
// Shared types and constants for the Huffman code bit packer.
package hcbp_pkg;

    localparam int WORD_BITS     = 64;
    localparam int SAMPLE_BITS   = 12;
    localparam int MAX_CODE_BITS = 32;
    localparam int LEN_W         = 6;
    localparam int POS_W         = $clog2(WORD_BITS);
    localparam int WBITS_W       = $clog2(WORD_BITS + 1);
    localparam int TOTAL_W       = 32;
    localparam int TABLE_DEPTH   = 1 << SAMPLE_BITS;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_ENCODE = 2'd1;
    localparam logic [1:0] OP_FLUSH  = 2'd2;

    typedef struct packed {
        logic [1:0]               opcode;
        logic [SAMPLE_BITS-1:0]   sample;
        logic [MAX_CODE_BITS-1:0] code_bits;
        logic [LEN_W-1:0]         code_length;
    } in_item_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] packed_word;
        logic [WBITS_W-1:0]   word_bits;
        logic                 is_final;
        logic [TOTAL_W-1:0]   total_bits;
    } out_item_t;

    typedef struct packed {
        logic [LEN_W-1:0]         len;
        logic [MAX_CODE_BITS-1:0] code;
    } entry_t;

    // Control of the pack stage: occupancy and operation
    typedef struct packed {
        logic       valid;
        logic [1:0] op;
    } stage_t;

endpackage

// File: src/huffman_code_bit_packer.sv
// A result passes the input item register, then the table read and pack control registers, then the result register.
// Throughput: one item per cycle while no stage stalls; table read and shift-or pack each take one stage.
// A stage stalls only when it has a result to hand off and the output slot is still taken.
// Reset (aresetn low, synchronous) clears stage valids, partial word, position and total.
// The code table is not cleared; entries are undefined until loaded.
module huffman_code_bit_packer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  hcbp_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output hcbp_pkg::out_item_t m_item
);

    logic               a_valid_reg;
    hcbp_pkg::in_item_t a_item_reg;
    hcbp_pkg::stage_t   b_reg;
    hcbp_pkg::entry_t   rd_entry;
    logic               b_ready;
    logic               a_move;

    // Advance the input stage into the pack stage when it has room
    assign a_move  = a_valid_reg && (!b_reg.valid || b_ready);
    assign s_ready = !a_valid_reg || a_move;

    // Hold the input item and the pack stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_reg       <= '0;
        end else begin
            if (s_ready) begin
                a_valid_reg <= s_valid;
            end
            if (a_move) begin
                b_reg.valid <= 1'b1;
                b_reg.op    <= a_item_reg.opcode;
            end else if (b_ready) begin
                b_reg.valid <= 1'b0;
            end
        end
        if (s_valid && s_ready) begin
            a_item_reg <= s_item;
        end
    end

    hcbp_table u_table (
        .aclk    (aclk),
        .wr_en   (a_move && (a_item_reg.opcode == hcbp_pkg::OP_LOAD)),
        .wr_addr (a_item_reg.sample),
        .wr_code (a_item_reg.code_bits),
        .wr_len  (a_item_reg.code_length),
        .rd_en   (a_move),
        .rd_addr (a_item_reg.sample),
        .rd_data (rd_entry)
    );

    hcbp_pack u_pack (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (b_reg),
        .entry       (rd_entry),
        .stage_ready (b_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item)
    );

    // Pack stage stalls only behind an occupied, untaken result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (b_reg.valid && !b_ready) |-> (m_valid && !m_ready))
        else $error("pack stage stalled with free output slot");

    // Full words carry exactly a word of bits, final words fewer
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item.is_final
            ? (m_item.word_bits < 7'(hcbp_pkg::WORD_BITS))
            : (m_item.word_bits == 7'(hcbp_pkg::WORD_BITS))))
        else $error("word_bits inconsistent with is_final");

    // The block total covers at least the bits handed out in this word
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item.total_bits >= 32'(m_item.word_bits)))
        else $error("total_bits below word_bits");

    // An empty input stage always takes a new item
    assert property (@(posedge aclk) disable iff (!aresetn)
        !a_valid_reg |-> s_ready)
        else $error("input stage empty but not ready");

endmodule

// File: src/hcbp_table.sv
// Code table memory with clamping on load and a registered read port.
module hcbp_table (
    input  logic                                 aclk,
    input  logic                                 wr_en,
    input  logic [hcbp_pkg::SAMPLE_BITS-1:0]     wr_addr,
    input  logic [hcbp_pkg::MAX_CODE_BITS-1:0]   wr_code,
    input  logic [hcbp_pkg::LEN_W-1:0]           wr_len,
    input  logic                                 rd_en,
    input  logic [hcbp_pkg::SAMPLE_BITS-1:0]     rd_addr,
    output hcbp_pkg::entry_t                     rd_data
);

    hcbp_pkg::entry_t mem [hcbp_pkg::TABLE_DEPTH];
    hcbp_pkg::entry_t wr_entry;
    logic [hcbp_pkg::LEN_W-1:0] len_clamped;
    logic [63:0]                code_mask;

    // Clamp the length and drop code bits above it
    always_comb begin
        if (wr_len > hcbp_pkg::LEN_W'(hcbp_pkg::MAX_CODE_BITS)) begin
            len_clamped = hcbp_pkg::LEN_W'(hcbp_pkg::MAX_CODE_BITS);
        end else begin
            len_clamped = wr_len;
        end
        code_mask     = (64'd1 << len_clamped) - 64'd1;
        wr_entry.len  = len_clamped;
        wr_entry.code = wr_code & code_mask[hcbp_pkg::MAX_CODE_BITS-1:0];
    end

    // Write on load, read registered on every advance
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_entry;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: src/hcbp_pack.sv
// Pack stage: shift-or of codes into the partial word and result register.
module hcbp_pack (
    input  logic                aclk,
    input  logic                aresetn,
    input  hcbp_pkg::stage_t    ctl,
    input  hcbp_pkg::entry_t    entry,
    output logic                stage_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output hcbp_pkg::out_item_t m_item
);

    localparam int W = hcbp_pkg::WORD_BITS;

    logic [W-1:0]                    word_reg, word_next;
    logic [hcbp_pkg::POS_W-1:0]      pos_reg, pos_next;
    logic [hcbp_pkg::TOTAL_W-1:0]    total_reg, total_next;
    logic                            m_valid_reg;
    hcbp_pkg::out_item_t             m_item_reg, m_item_next;

    logic [W-1:0]                    code_ext, merged, leftover;
    logic [hcbp_pkg::WBITS_W:0]      next_pos;
    logic [hcbp_pkg::WBITS_W-1:0]    used;
    logic [hcbp_pkg::TOTAL_W:0]      sum;
    logic                            full, produce, fire;

    // Compute the packed word, position and total for this item
    always_comb begin
        code_ext   = W'(entry.code);
        merged     = word_reg | (code_ext << pos_reg);
        next_pos   = (hcbp_pkg::WBITS_W + 1)'(pos_reg) + (hcbp_pkg::WBITS_W + 1)'(entry.len);
        full       = next_pos >= (hcbp_pkg::WBITS_W + 1)'(W);
        used       = hcbp_pkg::WBITS_W'(W) - hcbp_pkg::WBITS_W'(pos_reg);
        leftover   = code_ext >> used;
        sum        = {1'b0, total_reg} + (hcbp_pkg::TOTAL_W + 1)'(entry.len);

        word_next   = word_reg;
        pos_next    = pos_reg;
        total_next  = total_reg;
        produce     = 1'b0;
        m_item_next = m_item_reg;

        case (ctl.op)
            hcbp_pkg::OP_ENCODE: begin
                if (entry.len != '0) begin
                    total_next = sum[hcbp_pkg::TOTAL_W] ? '1 : sum[hcbp_pkg::TOTAL_W-1:0];
                    pos_next   = next_pos[hcbp_pkg::POS_W-1:0];
                    if (full) begin
                        produce                 = 1'b1;
                        word_next               = leftover;
                        m_item_next.packed_word = merged;
                        m_item_next.word_bits   = hcbp_pkg::WBITS_W'(W);
                        m_item_next.is_final    = 1'b0;
                        m_item_next.total_bits  = total_next;
                    end else begin
                        word_next = merged;
                    end
                end
            end
            hcbp_pkg::OP_FLUSH: begin
                produce                 = 1'b1;
                m_item_next.packed_word = word_reg;
                m_item_next.word_bits   = hcbp_pkg::WBITS_W'(pos_reg);
                m_item_next.is_final    = 1'b1;
                m_item_next.total_bits  = total_reg;
                word_next               = '0;
                pos_next                = '0;
                total_next              = '0;
            end
            default: begin
            end
        endcase
    end

    // Stall only an item that has a result to place while the slot is taken
    assign stage_ready = !(ctl.valid && produce && m_valid_reg && !m_ready);
    assign fire        = ctl.valid && stage_ready;

    // Hold packer state and the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_reg    <= '0;
            pos_reg     <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                word_reg  <= word_next;
                pos_reg   <= pos_next;
                total_reg <= total_next;
            end
            if (fire && produce) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (fire && produce) begin
            m_item_reg <= m_item_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

// File: bench/tb_top.sv
// Testbench for the Huffman code bit packer: random stimulus, in-order prediction and checking.
module tb_top;

    // Opcode that the block must ignore
    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam int         IDLE_LIMIT = 1000;
    localparam int         NUM_RANDOM = 1625;
    localparam int         QUIET_TAIL = 150;
    localparam int         DRAIN_WAIT = 8;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    hcbp_pkg::in_item_t  s_item  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    hcbp_pkg::out_item_t m_item;

    huffman_code_bit_packer i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Stimulus and expected results
    hcbp_pkg::in_item_t  pending_items[$];
    hcbp_pkg::out_item_t expected_words[$];

    // Predictor state: code table and packer
    logic [hcbp_pkg::MAX_CODE_BITS-1:0] tbl_code [hcbp_pkg::TABLE_DEPTH];
    int unsigned                        tbl_len  [hcbp_pkg::TABLE_DEPTH];
    logic [hcbp_pkg::WORD_BITS-1:0]     acc_word  = '0;
    int unsigned                        acc_pos   = 0;
    logic [hcbp_pkg::TOTAL_W-1:0]       acc_total = '0;

    // Generator bookkeeping: which entries are loaded so far
    bit gen_loaded [hcbp_pkg::TABLE_DEPTH];
    int gen_list[$];

    logic in_fire   = 1'b0;
    int   in_gap    = 0;
    int   out_stall = 0;
    int   errors    = 0;
    int   n_loads = 0, n_encodes = 0, n_flushes = 0, n_ignored = 0;
    int   n_full = 0, n_final = 0;

    // True in the last part of the run, where no idling is inserted
    function automatic bit quiet();
        return pending_items.size() < QUIET_TAIL;
    endfunction

    function automatic hcbp_pkg::in_item_t make_item(logic [1:0] op, int unsigned smp,
                                                     logic [31:0] code, int unsigned len);
        hcbp_pkg::in_item_t it;
        it.opcode      = op;
        it.sample      = hcbp_pkg::SAMPLE_BITS'(smp);
        it.code_bits   = code;
        it.code_length = hcbp_pkg::LEN_W'(len);
        return it;
    endfunction

    // Queue a load and remember the entry as readable
    task automatic add_load(int unsigned smp, logic [31:0] code, int unsigned len);
        pending_items.push_back(make_item(hcbp_pkg::OP_LOAD, smp, code, len));
        if (!gen_loaded[smp]) begin
            gen_loaded[smp] = 1'b1;
            gen_list.push_back(smp);
        end
    endtask

    task automatic add_op(logic [1:0] op, int unsigned smp);
        pending_items.push_back(make_item(op, smp, $urandom, $urandom_range(0, 63)));
    endtask

    // Update the packer model for one accepted item and queue its result, if any
    task automatic predict_packing(hcbp_pkg::in_item_t it);
        int unsigned                    len;
        int unsigned                    nxt;
        logic [31:0]                    code;
        logic [hcbp_pkg::WORD_BITS-1:0] code64;
        hcbp_pkg::out_item_t            res;
        case (it.opcode)
            hcbp_pkg::OP_LOAD: begin
                len = it.code_length;
                if (len > hcbp_pkg::MAX_CODE_BITS) len = hcbp_pkg::MAX_CODE_BITS;
                code = it.code_bits;
                if (len == 0) code = '0;
                else if (len < 32) code = code & ((32'd1 << len) - 32'd1);
                tbl_code[it.sample] = code;
                tbl_len[it.sample]  = len;
            end
            hcbp_pkg::OP_ENCODE: begin
                len    = tbl_len[it.sample];
                code64 = {32'd0, tbl_code[it.sample]};
                if (len != 0) begin
                    acc_word = acc_word | (code64 << acc_pos);
                    nxt = acc_pos + len;
                    if (acc_total > 32'hFFFF_FFFF - 32'(len)) acc_total = 32'hFFFF_FFFF;
                    else acc_total = acc_total + 32'(len);
                    if (nxt >= hcbp_pkg::WORD_BITS) begin
                        res.packed_word = acc_word;
                        res.word_bits   = hcbp_pkg::WBITS_W'(hcbp_pkg::WORD_BITS);
                        res.is_final    = 1'b0;
                        res.total_bits  = acc_total;
                        expected_words.push_back(res);
                        // Leftover high bits of the code start the next word
                        acc_word = code64 >> (hcbp_pkg::WORD_BITS - acc_pos);
                        acc_pos  = nxt - hcbp_pkg::WORD_BITS;
                    end else begin
                        acc_pos = nxt;
                    end
                end
            end
            hcbp_pkg::OP_FLUSH: begin
                res.packed_word = acc_word;
                res.word_bits   = hcbp_pkg::WBITS_W'(acc_pos);
                res.is_final    = 1'b1;
                res.total_bits  = acc_total;
                expected_words.push_back(res);
                acc_word  = '0;
                acc_pos   = 0;
                acc_total = '0;
            end
            default: ;
        endcase
    endtask

    // Drive the input channel from the pending queue, with random gaps
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !in_fire) begin
            // hold the item until it is accepted
        end else if (in_gap > 0) begin
            in_gap--;
            s_valid <= 1'b0;
        end else if (pending_items.size() == 0) begin
            s_valid <= 1'b0;
        end else if (!quiet() && $urandom_range(0, 9) == 0) begin
            in_gap = $urandom_range(1, 5) - 1;
            s_valid <= 1'b0;
        end else begin
            s_item  <= pending_items.pop_front();
            s_valid <= 1'b1;
        end
    end

    // Drive result backpressure in random bursts
    always @(negedge aclk) begin
        if (out_stall > 0) begin
            out_stall--;
            m_ready <= 1'b0;
        end else if (!quiet() && $urandom_range(0, 7) == 0) begin
            out_stall = $urandom_range(1, 5) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Sample both channels: predict on accepted inputs, check accepted results
    always @(posedge aclk) begin
        hcbp_pkg::out_item_t want;
        in_fire <= s_valid && s_ready;
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                $error("unexpected result: packed_word %h word_bits %0d",
                       m_item.packed_word, m_item.word_bits);
                errors++;
            end else begin
                want = expected_words.pop_front();
                if (m_item.packed_word !== want.packed_word) begin
                    $error("packed_word: expected %h, got %h",
                           want.packed_word, m_item.packed_word);
                    errors++;
                end
                if (m_item.word_bits !== want.word_bits) begin
                    $error("word_bits: expected %0d, got %0d", want.word_bits, m_item.word_bits);
                    errors++;
                end
                if (m_item.is_final !== want.is_final) begin
                    $error("is_final: expected %0d, got %0d", want.is_final, m_item.is_final);
                    errors++;
                end
                if (m_item.total_bits !== want.total_bits) begin
                    $error("total_bits: expected %0d, got %0d",
                           want.total_bits, m_item.total_bits);
                    errors++;
                end
                if (want.is_final) n_final++;
                else n_full++;
            end
        end
        if (aresetn && s_valid && s_ready) begin
            predict_packing(s_item);
            case (s_item.opcode)
                hcbp_pkg::OP_LOAD:   n_loads++;
                hcbp_pkg::OP_ENCODE: n_encodes++;
                hcbp_pkg::OP_FLUSH:  n_flushes++;
                default:             n_ignored++;
            endcase
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // Build the stimulus, release reset, wait for the drain and report
    initial begin
        int          r;
        int unsigned smp;
        int unsigned len;

        // Directed: extremes, clamped and stray bits, zero length, empty flush
        add_load(0, 32'hFFFF_FFFF, 32);
        add_load(hcbp_pkg::TABLE_DEPTH - 1, 32'hFFFF_FFFF, 3);
        add_load(1, 32'hDEAD_BEEF, 0);
        add_load(2, 32'hA5A5_A5A5, 63);
        add_load(3, 32'hFFFF_FFFF, 5);
        add_load(12'hAAA, 32'h5555_5555, 17);
        add_load(12'h555, 32'hAAAA_AAAA, 1);
        add_op(hcbp_pkg::OP_FLUSH, 0);
        add_op(hcbp_pkg::OP_ENCODE, 1);
        add_op(hcbp_pkg::OP_ENCODE, 0);
        add_op(hcbp_pkg::OP_ENCODE, 0);
        add_op(hcbp_pkg::OP_ENCODE, hcbp_pkg::TABLE_DEPTH - 1);
        add_op(hcbp_pkg::OP_ENCODE, 3);
        add_op(hcbp_pkg::OP_ENCODE, 2);
        add_op(hcbp_pkg::OP_ENCODE, 0);
        add_op(hcbp_pkg::OP_ENCODE, 12'hAAA);
        add_op(hcbp_pkg::OP_ENCODE, 12'h555);
        pending_items.push_back(make_item(OP_UNUSED, hcbp_pkg::TABLE_DEPTH - 1,
                                          32'hFFFF_FFFF, 63));
        pending_items.push_back(make_item(OP_UNUSED, 0, 32'd0, 0));
        add_op(hcbp_pkg::OP_FLUSH, 0);
        add_op(hcbp_pkg::OP_FLUSH, hcbp_pkg::TABLE_DEPTH - 1);
        add_op(hcbp_pkg::OP_ENCODE, 12'h555);
        add_op(hcbp_pkg::OP_FLUSH, 0);

        // Random: mostly encodes of loaded entries, some loads, flushes and noise
        for (int i = 0; i < NUM_RANDOM; i++) begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
                smp = ($urandom_range(0, 9) < 7)
                    ? $urandom_range(0, 63)
                    : $urandom_range(0, hcbp_pkg::TABLE_DEPTH - 1);
                case ($urandom_range(0, 9))
                    0:       len = 0;
                    1:       len = $urandom_range(hcbp_pkg::MAX_CODE_BITS + 1, 63);
                    2:       len = hcbp_pkg::MAX_CODE_BITS;
                    default: len = $urandom_range(1, hcbp_pkg::MAX_CODE_BITS);
                endcase
                add_load(smp, $urandom, len);
            end else if (r < 88) begin
                add_op(hcbp_pkg::OP_ENCODE, gen_list[$urandom_range(0, gen_list.size() - 1)]);
            end else if (r < 95) begin
                add_op(hcbp_pkg::OP_FLUSH, $urandom_range(0, hcbp_pkg::TABLE_DEPTH - 1));
            end else begin
                add_op(OP_UNUSED, $urandom_range(0, hcbp_pkg::TABLE_DEPTH - 1));
            end
        end
        add_op(hcbp_pkg::OP_FLUSH, 0);

        repeat (3) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        while (pending_items.size() != 0 || s_valid) @(negedge aclk);
        while (expected_words.size() != 0) @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);

        $display("Accepted %0d items: %0d loads, %0d encodes, %0d flushes, %0d ignored.",
                 n_loads + n_encodes + n_flushes + n_ignored,
                 n_loads, n_encodes, n_flushes, n_ignored);
        $display("Checked %0d full words and %0d final words, %0d mismatches.",
                 n_full, n_final, errors);
        if (errors == 0 && expected_words.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/hcbp_pkg.sv
src/hcbp_table.sv
src/hcbp_pack.sv
src/huffman_code_bit_packer.sv
bench/tb_top.sv
